/* sv/fpid_pkg.sv */
// Shared types and constants for the fixed-point PID step block.
`default_nettype none
package fpid_pkg;

   // Field widths
   localparam int DATA_W = 16;
   localparam int GAIN_W = 15;
   localparam int ACC_W  = 32;

   // Default fractional bits of the Q format
   localparam int FRAC_BITS_DEF = 14;

   // CSR port geometry: five 32-bit registers at 4-byte spacing
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [GAIN_W-1:0] KP_RST      = 15'd500;
   localparam logic [GAIN_W-1:0] KI_RST      = 15'd200;
   localparam logic [GAIN_W-1:0] KD_RST      = 15'd200;
   localparam logic [DATA_W-1:0] FLOOR_RST   = 16'd0;
   localparam logic [DATA_W-1:0] CEILING_RST = 16'h1000;

   // Register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_KP_GAIN       = 3'd0,
      REG_KI_GAIN       = 3'd1,
      REG_KD_GAIN       = 3'd2,
      REG_DRIVE_FLOOR   = 3'd3,
      REG_DRIVE_CEILING = 3'd4
   } csr_index_type;

   // Configuration handed to the step datapath
   typedef struct packed {
      logic [GAIN_W-1:0] kp_gain;
      logic [GAIN_W-1:0] ki_gain;
      logic [GAIN_W-1:0] kd_gain;
      logic [DATA_W-1:0] drive_floor;
      logic [DATA_W-1:0] drive_ceiling;
   } cfg_type;

   // Controller state read by the datapath
   typedef struct packed {
      logic [ACC_W-1:0]  integral_acc;
      logic [DATA_W-1:0] drive_now;
      logic [DATA_W-1:0] drive_before;
   } state_type;

endpackage
`default_nettype wire

/* sv/fpid_calc.sv */
// Combinational PID step: error, three products, accumulate, shift, clamp, then drive = ceiling - level.
`default_nettype none
module fpid_calc #(
   parameter int FRAC_BITS = fpid_pkg::FRAC_BITS_DEF
) (
   input  fpid_pkg::cfg_type                   cfg,
   input  fpid_pkg::state_type                 state,
   input  logic [fpid_pkg::DATA_W-1:0]         measured,
   input  logic [fpid_pkg::DATA_W-1:0]         target,
   output logic [fpid_pkg::ACC_W-1:0]          integral_next,
   output logic [fpid_pkg::DATA_W-1:0]         drive_next
);
   import fpid_pkg::*;

   logic signed [DATA_W:0]    err;
   logic signed [DATA_W:0]    drive_diff;
   logic signed [ACC_W:0]     p_prod;
   logic signed [ACC_W:0]     i_prod;
   logic signed [ACC_W:0]     d_prod;
   logic signed [ACC_W-1:0]   i_term;
   logic signed [ACC_W-1:0]   acc_new;
   logic signed [ACC_W-1:0]   sum;
   logic signed [ACC_W-1:0]   level_raw;
   logic signed [ACC_W-1:0]   floor_s;
   logic signed [ACC_W-1:0]   ceiling_s;
   logic signed [ACC_W-1:0]   level_lo;
   logic signed [ACC_W-1:0]   level;

   // Signed error and drive difference, 17 bits each
   assign err        = $signed({1'b0, measured}) - $signed({1'b0, target});
   assign drive_diff = $signed({1'b0, state.drive_now}) - $signed({1'b0, state.drive_before});

   // Gains are unsigned; products fit in 33 bits, low 32 kept (wraps as 32-bit)
   assign p_prod = $signed({1'b0, cfg.kp_gain}) * err;
   assign i_prod = $signed({1'b0, cfg.ki_gain}) * err;
   assign d_prod = $signed({1'b0, cfg.kd_gain}) * drive_diff;

   // Integral accumulates the scaled-down ki term
   assign i_term  = $signed(i_prod[ACC_W-1:0]) >>> FRAC_BITS;
   assign acc_new = $signed(state.integral_acc) + i_term;

   // Controller sum, scaled back to integer level
   assign sum       = $signed(p_prod[ACC_W-1:0]) + acc_new + $signed(d_prod[ACC_W-1:0]);
   assign level_raw = sum >>> FRAC_BITS;

   // Clamp: floor test first, then ceiling
   assign floor_s   = $signed({{(ACC_W-DATA_W){1'b0}}, cfg.drive_floor});
   assign ceiling_s = $signed({{(ACC_W-DATA_W){1'b0}}, cfg.drive_ceiling});
   assign level_lo  = (level_raw < floor_s) ? floor_s : level_raw;
   assign level     = (level_lo > ceiling_s) ? ceiling_s : level_lo;

   assign integral_next = acc_new;
   assign drive_next    = cfg.drive_ceiling - level[DATA_W-1:0];

endmodule
`default_nettype wire

/* sv/fixed_point_pid_step.sv */
// Path: a req transaction is captured in the input register, then the result register drives rsp_tvalid.
// Throughput: one transaction per cycle; the whole step is computed combinationally between
// the input register and the result register, gated only by rsp_tready backpressure.
// Reset (synchronous, active high): gains 500/200/200, floor 0, ceiling 4096,
// integral and both drive values cleared, both pipeline stages empty.
`default_nettype none
module fixed_point_pid_step #(
   parameter int FRAC_BITS = fpid_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [2*fpid_pkg::DATA_W-1:0]       req_tdata,   // [15:0] measured, [31:16] target
   // Result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fpid_pkg::DATA_W-1:0]         rsp_tdata,   // [15:0] drive
   // Configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fpid_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [fpid_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [fpid_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import fpid_pkg::*;

   cfg_type                 cfg_ff, cfg_in;
   state_type               state_ff, state_in;
   logic                    in_valid_ff, in_valid_in;
   logic [DATA_W-1:0]       measured_ff, target_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]       drive_ff;
   logic [ACC_W-1:0]        integral_next;
   logic [DATA_W-1:0]       drive_next;
   logic                    out_free;
   logic                    step_fire;
   logic                    req_take;
   logic                    csr_write;
   csr_index_type           csr_index;

   // CSR decode
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_KP_GAIN:       cfg_in.kp_gain       = csr_pwdata[GAIN_W-1:0];
            REG_KI_GAIN:       cfg_in.ki_gain       = csr_pwdata[GAIN_W-1:0];
            REG_KD_GAIN:       cfg_in.kd_gain       = csr_pwdata[GAIN_W-1:0];
            REG_DRIVE_FLOOR:   cfg_in.drive_floor   = csr_pwdata[DATA_W-1:0];
            REG_DRIVE_CEILING: cfg_in.drive_ceiling = csr_pwdata[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   // CSR readback
   always_comb begin
      case (csr_index)
         REG_KP_GAIN:       csr_prdata = {{(CSR_DATA_W-GAIN_W){1'b0}}, cfg_ff.kp_gain};
         REG_KI_GAIN:       csr_prdata = {{(CSR_DATA_W-GAIN_W){1'b0}}, cfg_ff.ki_gain};
         REG_KD_GAIN:       csr_prdata = {{(CSR_DATA_W-GAIN_W){1'b0}}, cfg_ff.kd_gain};
         REG_DRIVE_FLOOR:   csr_prdata = {{(CSR_DATA_W-DATA_W){1'b0}}, cfg_ff.drive_floor};
         REG_DRIVE_CEILING: csr_prdata = {{(CSR_DATA_W-DATA_W){1'b0}}, cfg_ff.drive_ceiling};
         default:           csr_prdata = '0;
      endcase
   end

   // Pipeline flow control: each stage advances when the next one frees up
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_fire  = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !step_fire);
   assign out_valid_in = step_fire || (out_valid_ff && !rsp_tready);

   // Step datapath
   fpid_calc #(
      .FRAC_BITS(FRAC_BITS)
   ) u_calc (
      .cfg           (cfg_ff),
      .state         (state_ff),
      .measured      (measured_ff),
      .target        (target_ff),
      .integral_next (integral_next),
      .drive_next    (drive_next)
   );

   // Controller state advances once per completed step
   always_comb begin
      state_in = state_ff;
      if (step_fire) begin
         state_in.integral_acc = integral_next;
         state_in.drive_before = state_ff.drive_now;
         state_in.drive_now    = drive_next;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain       <= KP_RST;
         cfg_ff.ki_gain       <= KI_RST;
         cfg_ff.kd_gain       <= KD_RST;
         cfg_ff.drive_floor   <= FLOOR_RST;
         cfg_ff.drive_ceiling <= CEILING_RST;
         state_ff             <= '0;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         measured_ff <= req_tdata[DATA_W-1:0];
         target_ff   <= req_tdata[2*DATA_W-1:DATA_W];
      end
      if (step_fire) begin
         drive_ff <= drive_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = drive_ff;

endmodule
`default_nettype wire
